// ===== hw/rtl/sdp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdp_pkg: shared types and constants of the sliding dot product block
// Command codes, window modes, register indexes, and the command / status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sdp_pkg;

    // Accumulator width, fixed by the result format
    localparam int SUM_BITS = 36;

    // Configuration port geometry
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 8;
    localparam int MODE_BITS      = 2;
    localparam int TAP_COUNT_BITS = 5;
    localparam int TAP_INDEX_BITS = 4;

    // Input command codes
    localparam logic CMD_TAP    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Output extent modes (code 3 behaves as full)
    localparam logic [MODE_BITS-1:0] MODE_VALID = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_SAME  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_FULL  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_MODE = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_COUNT   = 4'd1;

    // Register reset values
    localparam logic [MODE_BITS-1:0]      WINDOW_MODE_RESET = MODE_VALID;
    localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET   = 5'd16;

    // Controller to datapath commands
    typedef struct packed {
        logic tap_we;     // store a tap coefficient
        logic win_we;     // push a sample into the window ring
        logic rd_en;      // issue one multiply-accumulate term
        logic rd_zero;    // the issued term reads an empty window slot
        logic acc_clear;  // start a new sum
        logic out_load;   // move the finished sum into the output register
        logic out_final;  // flag that goes with out_load
    } sdp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic busy;       // terms still in the multiply pipeline
    } sdp_status_t;

endpackage

// ===== hw/rtl/sdp_ram.sv =====
// ----------------------------------------------------------------------------
// sdp_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdp_ctrl: controller of the sliding dot product block
// Holds the configuration registers and the stream fill count, plans the
// outputs each sample completes, and sequences the shared MAC term by term.
// ----------------------------------------------------------------------------
module sdp_ctrl #(
    parameter int MAX_TAPS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input channel handshake and control fields
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_command,
    input  logic                                  s_end_of_stream,
    // result channel handshake
    output logic                                  m_valid,
    input  logic                                  m_ready,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sdp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [sdp_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // datapath interface
    input  sdp_pkg::sdp_status_t                  status,
    output sdp_pkg::sdp_cmd_t                     cmd,
    output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0] rd_tap,
    output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0] rd_age
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW_RAW = $clog2(MAX_TAPS + 1);
    localparam int CW = (CW_RAW > sdp_pkg::TAP_COUNT_BITS) ? CW_RAW : sdp_pkg::TAP_COUNT_BITS;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_TAPS);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // State codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PLAN  = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [sdp_pkg::MODE_BITS-1:0]      mode_reg, mode_next;
    logic [sdp_pkg::TAP_COUNT_BITS-1:0] tap_count_reg, tap_count_next;
    logic [CW-1:0]                      seen_reg, seen_next;
    logic [CW-1:0]                      d_reg, d_next;
    logic [CW-1:0]                      dmax_reg, dmax_next;
    logic [CW-1:0]                      j_reg, j_next;
    logic                               eos_reg, eos_next;
    logic                               m_valid_reg, m_valid_next;

    logic [CW-1:0] tc_ext;
    logic [CW-1:0] taps;
    logic [CW-1:0] offset;
    logic [CW-1:0] fill;
    logic [CW-1:0] t_less_off;
    logic [CW-1:0] d_min;
    logic [CW-1:0] d_max;
    logic [CW-1:0] last_j;
    logic [CW-1:0] age;

    // Taps in use: zero acts as one, large counts saturate
    assign tc_ext = CW'(tap_count_reg);
    always_comb begin
        if (tc_ext == '0) begin
            taps = ONE_C;
        end else if (tc_ext > MAX_C) begin
            taps = MAX_C;
        end else begin
            taps = tc_ext;
        end
    end

    // Output extent of the current stream
    always_comb begin
        case (mode_reg)
            sdp_pkg::MODE_VALID: begin
                offset = '0;
                d_max  = '0;
            end
            sdp_pkg::MODE_SAME: begin
                offset = taps >> 1;
                d_max  = taps - ONE_C - (taps >> 1);
            end
            default: begin
                offset = taps - ONE_C;
                d_max  = taps - ONE_C;
            end
        endcase
    end

    assign fill       = (seen_reg < taps) ? seen_reg : taps;
    assign t_less_off = taps - offset;
    assign d_min      = (fill >= t_less_off) ? '0 : (t_less_off - fill);

    // Term addressing: tap j meets the sample of age t-1-d-j
    assign last_j = taps - ONE_C - d_reg;
    assign age    = last_j - j_reg;
    assign rd_tap = AW'(j_reg);
    assign rd_age = AW'(age);

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_comb begin
        mode_next      = mode_reg;
        tap_count_next = tap_count_reg;
        if (cfg_valid) begin
            case (cfg_index)
                sdp_pkg::REG_WINDOW_MODE: mode_next = cfg_data[sdp_pkg::MODE_BITS-1:0];
                sdp_pkg::REG_TAP_COUNT:   tap_count_next = cfg_data[sdp_pkg::TAP_COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        seen_next    = seen_reg;
        d_next       = d_reg;
        dmax_next    = dmax_reg;
        j_next       = j_reg;
        eos_next     = eos_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.rd_zero  = (age >= seen_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == sdp_pkg::CMD_TAP) begin
                        cmd.tap_we = 1'b1;
                    end else begin
                        cmd.win_we = 1'b1;
                        seen_next  = (seen_reg < MAX_C) ? seen_reg + ONE_C : seen_reg;
                        eos_next   = s_end_of_stream;
                        state_next = ST_PLAN;
                    end
                end
            end
            ST_PLAN: begin
                j_next = '0;
                if (!eos_reg) begin
                    d_next    = '0;
                    dmax_next = '0;
                    if (d_min == '0) begin
                        cmd.acc_clear = 1'b1;
                        state_next    = ST_ISSUE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (d_min <= d_max) begin
                    d_next        = d_min;
                    dmax_next     = d_max;
                    cmd.acc_clear = 1'b1;
                    state_next    = ST_ISSUE;
                end else begin
                    // short valid stream: nothing to send, just close it
                    seen_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_ISSUE: begin
                cmd.rd_en = 1'b1;
                if (j_reg == last_j) begin
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + ONE_C;
                end
            end
            ST_DRAIN: begin
                if (!status.busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_final = eos_reg && (d_reg == dmax_reg);
                    m_valid_next  = 1'b1;
                    if (eos_reg && (d_reg != dmax_reg)) begin
                        // tail flush: next output of the extent
                        d_next        = d_reg + ONE_C;
                        j_next        = '0;
                        cmd.acc_clear = 1'b1;
                        state_next    = ST_ISSUE;
                    end else begin
                        if (eos_reg) begin
                            seen_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= sdp_pkg::WINDOW_MODE_RESET;
            tap_count_reg <= sdp_pkg::TAP_COUNT_RESET;
            seen_reg      <= '0;
            d_reg         <= '0;
            dmax_reg      <= '0;
            j_reg         <= '0;
            eos_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            tap_count_reg <= tap_count_next;
            seen_reg      <= seen_next;
            d_reg         <= d_next;
            dmax_reg      <= dmax_next;
            j_reg         <= j_next;
            eos_reg       <= eos_next;
            m_valid_reg   <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/sdp_dpath.sv =====
// ----------------------------------------------------------------------------
// sdp_dpath: datapath of the sliding dot product block
// Tap RAM with valid bits, sample ring RAM, a registered multiplier and a
// 36-bit accumulator feeding the output register.
// ----------------------------------------------------------------------------
module sdp_dpath #(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  sdp_pkg::sdp_cmd_t                      cmd,
    input  logic [sdp_pkg::TAP_INDEX_BITS-1:0]     tap_index,
    input  logic signed [SAMPLE_BITS-1:0]          data_value,
    input  logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0] rd_tap,
    input  logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0] rd_age,
    output sdp_pkg::sdp_status_t                   status,
    output logic signed [sdp_pkg::SUM_BITS-1:0]    dot_sum,
    output logic                                   final_output
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PW = 2 * SAMPLE_BITS;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TAPS - 1);
    localparam logic [AW-1:0] DEPTH_A   = AW'(MAX_TAPS);

    logic [MAX_TAPS-1:0]                tap_valid_reg;
    logic [AW-1:0]                      newest_reg;
    logic                               v1_reg, v2_reg;
    logic                               z1_reg;
    logic signed [PW-1:0]               prod_reg;
    logic signed [sdp_pkg::SUM_BITS-1:0] acc_reg;
    logic signed [sdp_pkg::SUM_BITS-1:0] dot_sum_reg;
    logic                               final_reg;

    logic                   tap_in_range;
    logic                   tap_we;
    logic [AW-1:0]          tap_waddr;
    logic [AW-1:0]          win_waddr;
    logic [AW-1:0]          win_raddr;
    logic [SAMPLE_BITS-1:0] tap_rdata;
    logic [SAMPLE_BITS-1:0] win_rdata;

    // Tap writes outside the store are dropped
    assign tap_in_range = ({28'd0, tap_index} < 32'(MAX_TAPS));
    assign tap_we       = cmd.tap_we && tap_in_range;
    assign tap_waddr    = AW'(tap_index);

    // Sample ring: next slot after the newest, read back by age
    assign win_waddr = (newest_reg == LAST_SLOT) ? '0 : newest_reg + AW'(1);
    assign win_raddr = (newest_reg >= rd_age) ? (newest_reg - rd_age)
                                              : (newest_reg + DEPTH_A - rd_age);

    sdp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .aclk  (aclk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (data_value),
        .re    (cmd.rd_en),
        .raddr (rd_tap),
        .rdata (tap_rdata)
    );

    sdp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_win_ram (
        .aclk  (aclk),
        .we    (cmd.win_we),
        .waddr (win_waddr),
        .wdata (data_value),
        .re    (cmd.rd_en),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    // Tap valid bits and ring pointer; unwritten taps read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_valid_reg <= '0;
            newest_reg    <= LAST_SLOT;
        end else begin
            if (tap_we) begin
                tap_valid_reg[tap_waddr] <= 1'b1;
            end
            if (cmd.win_we) begin
                newest_reg <= win_waddr;
            end
        end
    end

    // MAC pipeline valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
        end
    end

    // Stage 1 zero mask, stage 2 product, stage 3 accumulate
    always_ff @(posedge aclk) begin
        z1_reg <= cmd.rd_zero || !tap_valid_reg[rd_tap];
        if (z1_reg) begin
            prod_reg <= '0;
        end else begin
            prod_reg <= signed'(win_rdata) * signed'(tap_rdata);
        end
        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + sdp_pkg::SUM_BITS'(prod_reg);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            dot_sum_reg <= acc_reg;
            final_reg   <= cmd.out_final;
        end
    end

    assign status.busy  = v1_reg || v2_reg;
    assign dot_sum      = dot_sum_reg;
    assign final_output = final_reg;

endmodule

// ===== hw/rtl/sliding_dot_product_1d.sv =====
// ----------------------------------------------------------------------------
// sliding_dot_product_1d: streaming 1-D correlation, valid / same / full
// Each accepted sample enters the window ring; the controller plans the outputs
// it completes and issues one MAC term per cycle for each, then waits for the
// multiply pipeline to drain and loads the output register. Input is held off
// until the block is idle again; outputs flushed at end of stream and result
// stalls hold it longer. Tap writes are taken while idle, off the shared MAC.
// Reset: synchronous active-low aresetn clears tap valid bits, fill and control.
// ----------------------------------------------------------------------------
module sliding_dot_product_1d #(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [sdp_pkg::TAP_INDEX_BITS-1:0]  s_tap_index,
    input  logic signed [SAMPLE_BITS-1:0]       s_data_value,
    input  logic                                s_end_of_stream,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [sdp_pkg::SUM_BITS-1:0] m_dot_sum,
    output logic                                m_final_output,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sdp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    sdp_pkg::sdp_cmd_t    cmd;
    sdp_pkg::sdp_status_t status;
    logic [AW-1:0]        rd_tap;
    logic [AW-1:0]        rd_age;

    // Controller
    sdp_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .status          (status),
        .cmd             (cmd),
        .rd_tap          (rd_tap),
        .rd_age          (rd_age)
    );

    // Datapath
    sdp_dpath #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .tap_index    (s_tap_index),
        .data_value   (s_data_value),
        .rd_tap       (rd_tap),
        .rd_age       (rd_age),
        .status       (status),
        .dot_sum      (m_dot_sum),
        .final_output (m_final_output)
    );

endmodule

// ===== hw/rtl/sdp_checker.sv =====
// ----------------------------------------------------------------------------
// sdp_checker: port-level assertions for sliding_dot_product_1d
// Watches the handshakes on the top level ports; bound to the top level.
// ----------------------------------------------------------------------------
module sdp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_command,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [sdp_pkg::SUM_BITS-1:0] m_dot_sum,
    input logic                                m_final_output
);

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_dot_sum) && $stable(m_final_output)))
        else $error("result changed while stalled");

    // A sample transaction occupies the block: no new input next cycle
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_valid && s_ready && (s_command == sdp_pkg::CMD_SAMPLE)) |=> !s_ready)
        else $error("input accepted right after a sample");

    // A tap write never raises a result
    a_tap_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_valid && s_ready && (s_command == sdp_pkg::CMD_TAP) && !m_valid)
            |=> !m_valid)
        else $error("result raised by a tap write");

    // Results pass through the MAC pipeline before they rise, not just after an input
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (!$past(s_valid && s_ready, 1) && !$past(s_valid && s_ready, 2)))
        else $error("result too soon after an input transaction");

endmodule

bind sliding_dot_product_1d sdp_checker u_sdp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_command      (s_command),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_dot_sum      (m_dot_sum),
    .m_final_output (m_final_output)
);

// ===== tb/dot_sum_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dot_sum_checker: predicts and checks the sliding dot product results
// Watches the configuration, input and result channels. Keeps its own copy of
// the taps, the sample history and the registers. Computes the sums that each
// accepted sample should produce and compares every result transaction, in
// order, against them.
// ----------------------------------------------------------------------------
module dot_sum_checker #(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_command,
    input  logic [sdp_pkg::TAP_INDEX_BITS-1:0]  s_tap_index,
    input  logic signed [SAMPLE_BITS-1:0]       s_data_value,
    input  logic                                s_end_of_stream,
    // result channel
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [sdp_pkg::SUM_BITS-1:0] m_dot_sum,
    input  logic                                m_final_output,
    // configuration channel
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [sdp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sdp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // status to the testbench top
    output int                                  error_count,
    output int                                  sums_pending,
    output int                                  sums_checked
);

    typedef struct {
        logic signed [sdp_pkg::SUM_BITS-1:0] sum;
        logic                                last_out;
    } dot_result_t;

    dot_result_t                           sums_expected[$];
    logic signed [SAMPLE_BITS-1:0]         tap_coef [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]         history  [MAX_TAPS];   // entry 0 is newest
    int                                    samples_held;
    logic [sdp_pkg::MODE_BITS-1:0]         mode_reg;
    logic [sdp_pkg::TAP_COUNT_BITS-1:0]    tap_count_reg;

    // Taps in use: zero acts as one, oversize saturates
    function automatic int taps_active();
        if (tap_count_reg == 0) return 1;
        if (tap_count_reg > MAX_TAPS) return MAX_TAPS;
        return int'(tap_count_reg);
    endfunction

    // Sum for the window that starts d samples after the oldest of the last t;
    // terms past the newest sample are zero
    function automatic logic signed [sdp_pkg::SUM_BITS-1:0] window_dot(input int t,
                                                                     input int d);
        longint acc;
        acc = 0;
        for (int j = 0; j < t - d; j++)
            acc += longint'(history[t - 1 - d - j]) * longint'(tap_coef[j]);
        return acc[sdp_pkg::SUM_BITS-1:0];
    endfunction

    task automatic push_sum(input logic signed [sdp_pkg::SUM_BITS-1:0] sum,
                            input logic last_out);
        dot_result_t r;
        r.sum      = sum;
        r.last_out = last_out;
        sums_expected.push_back(r);
    endtask

    // Shift in a sample and queue the sums it completes
    task automatic predict_sample_sums(input logic signed [SAMPLE_BITS-1:0] value,
                                       input logic closing);
        int t, offset, seen, d_min, d_max;
        for (int k = MAX_TAPS - 1; k > 0; k--)
            history[k] = history[k - 1];
        history[0] = value;
        if (samples_held < MAX_TAPS)
            samples_held++;

        t = taps_active();
        case (mode_reg)
            sdp_pkg::MODE_VALID: begin
                offset = 0;
                d_max  = 0;
            end
            sdp_pkg::MODE_SAME: begin
                offset = t / 2;
                d_max  = t - 1 - offset;
            end
            default: begin
                offset = t - 1;
                d_max  = t - 1;
            end
        endcase
        seen  = (samples_held < t) ? samples_held : t;
        d_min = (seen >= t - offset) ? 0 : t - offset - seen;

        if (!closing) begin
            if (d_min == 0)
                push_sum(window_dot(t, 0), 1'b0);
        end else begin
            // end of stream: flush the tail, flag the last sum, clear the history
            for (int d = d_min; d <= d_max; d++)
                push_sum(window_dot(t, d), d == d_max);
            foreach (history[k])
                history[k] = '0;
            samples_held = 0;
        end
    endtask

    task automatic check_result();
        dot_result_t want;
        if (sums_expected.size() == 0) begin
            $error("unexpected result transaction: dot_sum %0d final_output %0b",
                   m_dot_sum, m_final_output);
            error_count++;
        end else begin
            want = sums_expected.pop_front();
            sums_checked++;
            if (m_dot_sum !== want.sum) begin
                $error("dot_sum mismatch: expected %0d, actual %0d", want.sum, m_dot_sum);
                error_count++;
            end
            if (m_final_output !== want.last_out) begin
                $error("final_output mismatch: expected %0b, actual %0b",
                       want.last_out, m_final_output);
                error_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (tap_coef[k])
                tap_coef[k] = '0;
            foreach (history[k])
                history[k] = '0;
            samples_held  = 0;
            mode_reg      = sdp_pkg::WINDOW_MODE_RESET;
            tap_count_reg = sdp_pkg::TAP_COUNT_RESET;
            sums_expected.delete();
            error_count   = 0;
            sums_checked  = 0;
        end else begin
            // register writes; unknown indexes are ignored
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == sdp_pkg::REG_WINDOW_MODE)
                    mode_reg = cfg_data[sdp_pkg::MODE_BITS-1:0];
                else if (cfg_index == sdp_pkg::REG_TAP_COUNT)
                    tap_count_reg = cfg_data[sdp_pkg::TAP_COUNT_BITS-1:0];
            end
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready) begin
                if (s_command == sdp_pkg::CMD_SAMPLE)
                    predict_sample_sums(s_data_value, s_end_of_stream);
                else if (s_tap_index < MAX_TAPS)
                    tap_coef[s_tap_index] = s_data_value;
            end
        end
        sums_pending = sums_expected.size();
    end

endmodule

// ===== tb/sliding_dot_product_1d_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_dot_product_1d_tb: stimulus and verdict for the sliding dot product
// Directed streams cover the field extremes, every window mode, odd tap counts
// and short or interleaved streams; then random phases reload taps and stream
// samples under mixed sender gaps and receiver stalls. A separate checker
// predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module sliding_dot_product_1d_tb;

    localparam int MAX_TAPS       = 16;
    localparam int SAMPLE_BITS    = 16;
    localparam int RANDOM_ITEMS   = 140;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam int SUM_BITS       = sdp_pkg::SUM_BITS;
    localparam int CFG_INDEX_BITS = sdp_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_BITS  = sdp_pkg::CFG_DATA_BITS;
    localparam int MODE_BITS      = sdp_pkg::MODE_BITS;
    localparam int TAP_COUNT_BITS = sdp_pkg::TAP_COUNT_BITS;
    localparam int TAP_INDEX_BITS = sdp_pkg::TAP_INDEX_BITS;

    localparam logic [CFG_INDEX_BITS-1:0]   REG_UNUSED    = 4'd14;
    localparam logic [MODE_BITS-1:0]        MODE_FULL_ALT = 2'd3;
    localparam logic signed [SAMPLE_BITS-1:0] DATA_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] DATA_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic                          aclk;
    logic                          aresetn         = 1'b0;
    logic                          s_valid         = 1'b0;
    logic                          s_command       = sdp_pkg::CMD_TAP;
    logic [TAP_INDEX_BITS-1:0]     s_tap_index     = '0;
    logic signed [SAMPLE_BITS-1:0] s_data_value    = '0;
    logic                          s_end_of_stream = 1'b0;
    logic                          m_ready         = 1'b0;
    logic                          cfg_valid       = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     cfg_index       = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data        = '0;
    logic                          s_ready;
    logic                          m_valid;
    logic signed [SUM_BITS-1:0]    m_dot_sum;
    logic                          m_final_output;
    logic                          cfg_ready;

    int error_count;
    int sums_pending;
    int sums_checked;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int samples_sent   = 0;
    int streams_closed = 0;

    sliding_dot_product_1d #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_tap_index     (s_tap_index),
        .s_data_value    (s_data_value),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dot_sum       (m_dot_sum),
        .m_final_output  (m_final_output),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    dot_sum_checker #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dot_sum_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_tap_index     (s_tap_index),
        .s_data_value    (s_data_value),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dot_sum       (m_dot_sum),
        .m_final_output  (m_final_output),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .sums_pending    (sums_pending),
        .sums_checked    (sums_checked)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too long without any transaction on any channel
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Idle mixes: none, sender gaps, receiver stalls, both lightly
    task automatic set_profile(input int p);
        case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_data(input bit extremes);
        if (extremes)
            return ($urandom_range(3) != 0) ? DATA_MIN : DATA_MAX;
        if ($urandom_range(7) < 2)
            return $urandom_range(1) ? DATA_MAX : DATA_MIN;
        return SAMPLE_BITS'($urandom);
    endfunction

    // One input transaction; returns at the edge that accepted it
    task automatic send_item(input logic cmd, input logic [TAP_INDEX_BITS-1:0] idx,
                             input logic signed [SAMPLE_BITS-1:0] value, input logic eos);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_tap_index     <= idx;
        s_data_value    <= value;
        s_end_of_stream <= eos;
        @(negedge aclk);
        while (!s_ready)
            @(negedge aclk);
        @(posedge aclk);
        items_sent++;
        if (cmd == sdp_pkg::CMD_SAMPLE) begin
            samples_sent++;
            if (eos)
                streams_closed++;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(negedge aclk);
        while (!cfg_ready)
            @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold the sender until every expected sum is in, then let the block go idle
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        @(negedge aclk);
        while (sums_pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int                         phase, taps_used, stream_len, directed_items;
        logic [MODE_BITS-1:0]       mode;
        logic [TAP_COUNT_BITS-1:0]  count;
        logic [CFG_DATA_BITS-1:0]   cfg;
        bit                         extremes, closing;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: full mode, three taps, extreme values, end mark on a tap write
        set_profile(0);
        write_reg(sdp_pkg::REG_TAP_COUNT, 8'd3);
        write_reg(sdp_pkg::REG_WINDOW_MODE, CFG_DATA_BITS'(sdp_pkg::MODE_FULL));
        send_item(sdp_pkg::CMD_TAP, 4'd0, DATA_MIN, 1'b0);
        send_item(sdp_pkg::CMD_TAP, 4'd1, DATA_MAX, 1'b0);
        send_item(sdp_pkg::CMD_TAP, 4'd2, DATA_MIN, 1'b1);
        send_item(sdp_pkg::CMD_TAP, 4'd15, DATA_MAX, 1'b0);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, DATA_MIN, 1'b0);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd15, DATA_MIN, 1'b0);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, DATA_MAX, 1'b1);

        // Valid stream shorter than the taps: nothing comes out
        settle();
        write_reg(sdp_pkg::REG_WINDOW_MODE, CFG_DATA_BITS'(sdp_pkg::MODE_VALID));
        write_reg(sdp_pkg::REG_TAP_COUNT, 8'd4);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, 16'sd5, 1'b0);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, -16'sd7, 1'b1);

        // Mode three acts as full, tap count zero acts as one
        settle();
        write_reg(sdp_pkg::REG_WINDOW_MODE, CFG_DATA_BITS'(MODE_FULL_ALT));
        write_reg(sdp_pkg::REG_TAP_COUNT, 8'd0);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, DATA_MAX, 1'b0);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, DATA_MIN, 1'b1);

        // Same mode, oversize tap count, tap written mid stream
        settle();
        write_reg(sdp_pkg::REG_WINDOW_MODE, CFG_DATA_BITS'(sdp_pkg::MODE_SAME));
        write_reg(sdp_pkg::REG_TAP_COUNT, 8'd31);
        send_item(sdp_pkg::CMD_TAP, 4'd8, -16'sd1, 1'b0);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, 16'sd1, 1'b0);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, 16'sd2, 1'b0);
        send_item(sdp_pkg::CMD_TAP, 4'd3, 16'sd100, 1'b0);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, 16'sd3, 1'b0);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, 16'sd4, 1'b1);

        // Unknown register index, then a plain valid stream
        settle();
        write_reg(REG_UNUSED, 8'hFF);
        write_reg(sdp_pkg::REG_WINDOW_MODE, CFG_DATA_BITS'(sdp_pkg::MODE_VALID));
        write_reg(sdp_pkg::REG_TAP_COUNT, 8'd2);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, 16'sd1, 1'b0);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, -16'sd1, 1'b0);
        send_item(sdp_pkg::CMD_SAMPLE, 4'd0, 16'sd2, 1'b1);
        directed_items = items_sent;

        // Random phases: new settings, reload taps, stream samples
        phase = 0;
        while (items_sent - directed_items < RANDOM_ITEMS) begin
            settle();
            set_profile(phase % 4);
            extremes = (phase % 5 == 4);
            mode = MODE_BITS'($urandom_range(3));
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: count = TAP_COUNT_BITS'($urandom_range(1, 6));
                6, 7:             count = TAP_COUNT_BITS'($urandom_range(7, 15));
                8:                count = TAP_COUNT_BITS'(MAX_TAPS);
                default:          count = $urandom_range(1) ? '0
                                          : TAP_COUNT_BITS'($urandom_range(17, 31));
            endcase
            if (extremes) begin
                mode  = sdp_pkg::MODE_FULL;
                count = TAP_COUNT_BITS'(MAX_TAPS);
            end

            // upper data bits are don't-care; set them half the time
            cfg = CFG_DATA_BITS'($urandom);
            cfg[MODE_BITS-1:0] = mode;
            if ($urandom_range(1))
                cfg[CFG_DATA_BITS-1:MODE_BITS] = '0;
            write_reg(sdp_pkg::REG_WINDOW_MODE, cfg);
            cfg = CFG_DATA_BITS'($urandom);
            cfg[TAP_COUNT_BITS-1:0] = count;
            if ($urandom_range(1))
                cfg[CFG_DATA_BITS-1:TAP_COUNT_BITS] = '0;
            write_reg(sdp_pkg::REG_TAP_COUNT, cfg);

            if (count == 0)
                taps_used = 1;
            else if (count > MAX_TAPS)
                taps_used = MAX_TAPS;
            else
                taps_used = count;

            for (int k = 0; k < taps_used; k++)
                if (extremes || $urandom_range(3) != 0)
                    send_item(sdp_pkg::CMD_TAP, TAP_INDEX_BITS'(k), rand_data(extremes),
                              1'($urandom_range(1)));
            if ($urandom_range(3) == 0)
                send_item(sdp_pkg::CMD_TAP, TAP_INDEX_BITS'($urandom), rand_data(1'b0),
                          1'($urandom_range(1)));

            stream_len = extremes ? taps_used + 2 : $urandom_range(1, 2 * taps_used + 2);
            for (int k = 0; k < stream_len; k++) begin
                if ($urandom_range(9) == 0)
                    send_item(sdp_pkg::CMD_TAP, TAP_INDEX_BITS'($urandom), rand_data(1'b0),
                              1'($urandom_range(1)));
                // now and then the stream stays open into the next phase
                closing = (k == stream_len - 1) && ($urandom_range(5) != 0);
                send_item(sdp_pkg::CMD_SAMPLE, TAP_INDEX_BITS'($urandom),
                          rand_data(extremes), closing);
            end
            phase++;
        end

        settle();
        $display("Sent %0d items (%0d samples, %0d closed streams), checked %0d sums",
                 items_sent, samples_sent, streams_closed, sums_checked);
        $display("Covered all window modes, tap counts from zero to oversize, four idle mixes");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sdp_pkg.sv
hw/rtl/sdp_ram.sv
hw/rtl/sdp_ctrl.sv
hw/rtl/sdp_dpath.sv
hw/rtl/sliding_dot_product_1d.sv
hw/rtl/sdp_checker.sv
tb/dot_sum_checker.sv
tb/sliding_dot_product_1d_tb.sv
